FILE: rtl/core/uatd_pkg.sv
// Package for the unsigned-to-ASCII digit converter.
// Holds the digit cell control struct, the state encoding and the glyph function.
// No dependencies.
package uatd_pkg;

  localparam int VALUE_W   = 32;  // width of the input value field
  localparam int BUF_DEPTH = 10;  // digit cells, enough for any 32-bit decimal value
  localparam int IDX_W     = $clog2(BUF_DEPTH);
  localparam int CHAR_W    = 7;
  localparam int DIGIT_W   = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'h61;  // 'a'

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;  // start a new conversion
    logic shift;  // take one value bit into the chain
    logic hex;    // radix sixteen: no decimal correction
  } cell_ctrl_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/uatd_cell.sv
// One digit cell of the shift-and-add-three chain.
// Depends on uatd_pkg for the control struct.
module uatd_cell (
  input  logic                               clk,
  input  uatd_pkg::cell_ctrl_t               ctrl,
  input  logic                               bit_in,
  output logic                               bit_out,
  output logic [uatd_pkg::DIGIT_W-1:0]       digit
);
  import uatd_pkg::*;

  logic [DIGIT_W-1:0] adj;

  // Correct a decimal digit of five or more before the shift so it carries out.
  always_comb begin
    if (!ctrl.hex && (digit >= 4'd5)) begin
      adj = digit + 4'd3;
    end else begin
      adj = digit;
    end
  end

  assign bit_out = adj[DIGIT_W-1];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.shift) begin
      digit <= {adj[DIGIT_W-2:0], bit_in};
    end
  end

endmodule

FILE: rtl/core/unsigned_to_ascii_digits.sv
// Top level of the unsigned-to-ASCII digit converter.
// Depends on uatd_pkg and instantiates a row of uatd_cell digit cells.
//
// Usage:
//   Slave channel: s_tdata carries the value, s_tuser selects the radix
//   (0 decimal, 1 lower-case hexadecimal). One transfer is one number.
//   Master channel: one transfer per digit, most significant first; m_tdata
//   holds the ASCII character and m_tlast marks the least significant digit.
//   Zero gives the single character '0'; no terminator follows.
// Operation:
//   The value bits enter a row of ten digit cells one bit per cycle, most
//   significant first; each cell corrects its digit (decimal only) and passes its
//   top bit to the next cell. Only the low min(VALUE_BITS, 32) bits are converted;
//   a scan state then finds the leading digit, and the digits are loaded into
//   the output register in turn. One number is worked on at a time; s_tready
//   is high only between numbers.
// Reset: rst (synchronous, active high) empties the output register and
//   returns to idle; any number in flight is dropped.
// Stall: while m_tready is low the pending digit holds in the output register
//   and the digit sequencer waits. The final digit may still wait there while
//   the next number is accepted and converted.
module unsigned_to_ascii_digits #(
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [uatd_pkg::VALUE_W-1:0]  s_tdata,   // [31:0] value
  input  logic                          s_tuser,   // [0] hex_mode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [6:0] digit_char, [7] zero
  output logic                          m_tlast    // last_digit
);
  import uatd_pkg::*;

  // Only the low bits of the value take part.
  localparam int EFF_BITS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int CNT_W    = $clog2(EFF_BITS + 1);

  state_t               state, state_next;
  cell_ctrl_t           ctrl;
  logic [EFF_BITS-1:0]  shreg;
  logic [CNT_W-1:0]     bits_left;
  logic                 hex;
  logic [IDX_W-1:0]     sel;
  logic [IDX_W-1:0]     top_idx;
  logic                 load_out;
  logic                 dec_ok;

  logic [BUF_DEPTH:0]   chain;
  logic [DIGIT_W-1:0]   digits [BUF_DEPTH];

  // Row of digit cells: the value enters at cell 0, carries move upwards.
  assign chain[0] = shreg[EFF_BITS-1];

  for (genvar i = 0; i < BUF_DEPTH; i++) begin : g_cell
    uatd_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .bit_in  (chain[i]),
      .bit_out (chain[i+1]),
      .digit   (digits[i])
    );
  end

  // Locate the most significant non-zero digit; zero keeps index 0.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      if (digits[i] != '0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  // Every digit in range for decimal; used by a check below.
  always_comb begin
    dec_ok = 1'b1;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      if (digits[i] > 4'd9) begin
        dec_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    ctrl       = '0;
    ctrl.hex   = hex;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.clear = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.shift = 1'b1;
        if (bits_left == CNT_W'(1)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // Advance only when the output register is free or being emptied.
        if (!m_tvalid || m_tready) begin
          load_out = 1'b1;
          if (sel == '0) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Value shifter, bit counter, radix flag and digit pointer.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      shreg     <= s_tdata[EFF_BITS-1:0];
      bits_left <= CNT_W'(EFF_BITS);
      hex       <= s_tuser;
    end else if (ctrl.shift) begin
      shreg     <= shreg << 1;
      bits_left <= bits_left - CNT_W'(1);
    end
    if (state == ST_SCAN) begin
      sel <= top_idx;
    end else if (load_out) begin
      sel <= sel - IDX_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {1'b0, glyph(digits[sel])};
      m_tlast <= (sel == '0);
    end
  end

  // A number never overflows the row of cells.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> !chain[BUF_DEPTH])
    else $error("carry left the last digit cell");

  // The digit pointer stays inside the row while emitting.
  a_sel_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (sel < IDX_W'(BUF_DEPTH)))
    else $error("digit pointer out of range");

  // Decimal conversions leave only decimal digits.
  a_dec_digits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !hex) |-> dec_ok)
    else $error("decimal cell holds a digit above nine");

  // Once the final digit is loaded the sequencer has left the emit state.
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (load_out && sel == '0) |=> (state != ST_EMIT))
    else $error("sequencer still emitting after the final digit");

  // An accepted number starts the conversion.
  a_accept_conv: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_CONV))
    else $error("accepted number did not start conversion");

endmodule
